// File: sv/ktsc_pkg.sv
// Shared types, command and status codes, alphabet and helpers for the keyword table cipher.
`timescale 1ns / 1ps
`default_nettype none

package ktsc_pkg;

    // Column count is fixed; row count is a top-level parameter.
    localparam int TABLE_COLS  = 8;
    localparam int COL_W       = 3;

    localparam int ALPHA_LEN   = 64;
    localparam int ALPHA_IDX_W = 6;
    localparam int ALPHA_CNT_W = 7;

    localparam logic [2:0] CMD_CLEAR   = 3'd0;
    localparam logic [2:0] CMD_KEY     = 3'd1;
    localparam logic [2:0] CMD_FINISH  = 3'd2;
    localparam logic [2:0] CMD_ENCRYPT = 3'd3;
    localparam logic [2:0] CMD_DECRYPT = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MISS      = 2'd1;
    localparam logic [1:0] ST_NOT_READY = 2'd2;

    // Latin capitals, Cyrillic capitals with YO after YE, then punctuation.
    localparam logic [7:0] ALPHABET [0:ALPHA_LEN-1] = '{
        8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48,
        8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50,
        8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58,
        8'h59, 8'h5A, 8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'hC5,
        8'hA8, 8'hC6, 8'hC7, 8'hC8, 8'hC9, 8'hCA, 8'hCB, 8'hCC,
        8'hCD, 8'hCE, 8'hCF, 8'hD0, 8'hD1, 8'hD2, 8'hD3, 8'hD4,
        8'hD5, 8'hD6, 8'hD7, 8'hD8, 8'hD9, 8'hDA, 8'hDB, 8'hDC,
        8'hDD, 8'hDE, 8'hDF, 8'h20, 8'h2C, 8'h2E, 8'h3F, 8'h21
    };

    typedef struct packed {
        logic       start;
        logic [7:0] key;
    } scan_ctl_t;

    typedef struct packed {
        logic done;
        logic hit;
    } scan_res_t;

    // Map lowercase Latin, lowercase cp1251 Cyrillic and small yo to capitals.
    function automatic logic [7:0] cap_char(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h61 && c <= 8'h7A) begin
            r = c - 8'h20;
        end
        else if (c >= 8'hE0) begin
            r = c - 8'h20;
        end
        else if (c == 8'hB8) begin
            r = 8'hA8;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/ktsc_req_if.sv
// Request channel: command and character with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface ktsc_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] in_char;

    modport source (output valid, output cmd, output in_char, input ready);
    modport sink   (input valid, input cmd, input in_char, output ready);
endinterface

`default_nettype wire

// File: sv/ktsc_rsp_if.sv
// Response channel: output character and status with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface ktsc_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic [1:0] status;

    modport source (output valid, output out_char, output status, input ready);
    modport sink   (input valid, input out_char, input status, output ready);
endinterface

`default_nettype wire

// File: sv/ktsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ktsc_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: sv/ktsc_scan.sv
// Shared search unit: walks the valid table entries one per cycle and compares each to a key.
`timescale 1ns / 1ps
`default_nettype none

module ktsc_scan
    import ktsc_pkg::*;
#(
    parameter int AW = 6,
    parameter int CW = 7
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire scan_ctl_t     ctl,
    input  wire logic [CW-1:0] count,
    input  wire logic [7:0]    rd_data,
    output logic      [AW-1:0] rd_addr,
    output scan_res_t          res,
    output logic      [AW-1:0] pos
);

    logic          active_reg;
    logic          cmp_valid_reg;
    logic          done_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] cnt_reg;
    logic [7:0]    key_reg;
    logic [AW-1:0] cmp_pos_reg;
    logic [AW-1:0] pos_reg;
    logic          hit_reg;

    logic match;
    logic issue;
    logic ending;

    always_comb
    begin
        match  = cmp_valid_reg && (rd_data == key_reg);
        issue  = active_reg && (idx_reg < cnt_reg);
        ending = active_reg && (match || !issue);
    end

    assign rd_addr = idx_reg[AW-1:0];
    assign res     = '{done: done_reg, hit: hit_reg};
    assign pos     = pos_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            idx_reg       <= '0;
        end
        else if (ctl.start)
        begin
            active_reg    <= 1'b1;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            done_reg      <= ending;
            cmp_valid_reg <= issue && !ending;
            if (ending)
            begin
                active_reg <= 1'b0;
            end
            if (issue)
            begin
                idx_reg <= idx_reg + CW'(1);
            end
        end
    end

    // Key, bound, pipeline position and verdict carry no reset.
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            key_reg <= ctl.key;
            cnt_reg <= count;
        end
        cmp_pos_reg <= idx_reg[AW-1:0];
        if (!ctl.start && ending)
        begin
            hit_reg <= match;
            pos_reg <= cmp_pos_reg;
        end
    end

endmodule

`default_nettype wire

// File: sv/keyword_table_substitution_cipher_unit.sv
// Top level: command sequencer, symbol table RAM and shared search unit of the keyword cipher.
// Clear and unused commands complete without a search; a key character (unless the table is full)
// and a ready encrypt or decrypt search the filled entries, one table entry compared per cycle.
// Finish runs one search per alphabet symbol until the table is full or the alphabet is exhausted.
// One item at a time; req.ready is high only when the sequencer is idle.
// Reset clears the fill count, the ready flag, the sequencer and the output valid; table
// contents stay undefined and are never read before they are written.
`timescale 1ns / 1ps
`default_nettype none

module keyword_table_substitution_cipher_unit
    import ktsc_pkg::*;
#(
    parameter int TABLE_ROWS = 8
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ktsc_req_if.sink    req,
    ktsc_rsp_if.source  rsp
);

    localparam int SIZE = TABLE_ROWS * TABLE_COLS;
    localparam int AW   = $clog2(SIZE);
    localparam int CW   = $clog2(SIZE + 1);
    localparam int RW   = AW - COL_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY_SCAN,
        S_FIN_NEXT,
        S_FIN_SCAN,
        S_CIPH_SCAN,
        S_LOOKUP,
        S_LOOKUP_DATA,
        S_DONE
    } state_t;

    state_t                 state_reg;
    logic [CW-1:0]          fill_reg;
    logic                   tbl_ready_reg;
    logic [2:0]             cmd_reg;
    logic [7:0]             char_reg;
    logic [7:0]             key_reg;
    logic [ALPHA_CNT_W-1:0] alpha_reg;
    logic                   scan_go_reg;
    logic [AW-1:0]          lu_addr_reg;
    logic [7:0]             res_char_reg;
    logic [1:0]             res_status_reg;
    logic                   out_valid_reg;
    logic [7:0]             out_char_reg;
    logic [1:0]             out_status_reg;

    logic          accept;
    logic          table_full;
    logic          wr_en;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] scan_addr;
    logic [AW-1:0] scan_pos;
    logic [7:0]    rd_data;
    logic [RW-1:0] row;
    logic [RW-1:0] nrow;
    logic [AW-1:0] lu_addr_next;
    scan_ctl_t     scan_ctl;
    scan_res_t     scan_res;

    assign req.ready    = (state_reg == S_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.out_char = out_char_reg;
    assign rsp.status   = out_status_reg;

    always_comb
    begin
        accept     = req.valid && req.ready;
        table_full = (fill_reg == CW'(SIZE));
        scan_ctl   = '{start: scan_go_reg, key: key_reg};
        wr_en      = (state_reg == S_KEY_SCAN || state_reg == S_FIN_SCAN)
                     && scan_res.done && !scan_res.hit;
        rd_addr    = (state_reg == S_LOOKUP) ? lu_addr_reg : scan_addr;

        // Same column, one row down for encrypt, one row up for decrypt, wrapping.
        row = scan_pos[AW-1:COL_W];
        if (cmd_reg == CMD_ENCRYPT)
        begin
            nrow = (row == RW'(TABLE_ROWS - 1)) ? '0 : row + RW'(1);
        end
        else
        begin
            nrow = (row == '0) ? RW'(TABLE_ROWS - 1) : row - RW'(1);
        end
        lu_addr_next = {nrow, scan_pos[COL_W-1:0]};
    end

    ktsc_ram #(
        .WIDTH (8),
        .DEPTH (SIZE)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (key_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ktsc_scan #(
        .AW (AW),
        .CW (CW)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (scan_ctl),
        .count   (fill_reg),
        .rd_data (rd_data),
        .rd_addr (scan_addr),
        .res     (scan_res),
        .pos     (scan_pos)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            tbl_ready_reg  <= 1'b0;
            cmd_reg        <= CMD_CLEAR;
            char_reg       <= '0;
            key_reg        <= '0;
            alpha_reg      <= '0;
            scan_go_reg    <= 1'b0;
            lu_addr_reg    <= '0;
            res_char_reg   <= '0;
            res_status_reg <= ST_OK;
            out_valid_reg  <= 1'b0;
            out_char_reg   <= '0;
            out_status_reg <= ST_OK;
        end
        else
        begin
            // S_DONE reloads the output register on its own.
            if (out_valid_reg && rsp.ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg        <= req.cmd;
                        char_reg       <= req.in_char;
                        res_char_reg   <= '0;
                        res_status_reg <= ST_OK;
                        unique case (req.cmd)
                            CMD_CLEAR:
                            begin
                                fill_reg      <= '0;
                                tbl_ready_reg <= 1'b0;
                                state_reg     <= S_DONE;
                            end
                            CMD_KEY:
                            begin
                                key_reg <= cap_char(req.in_char);
                                if (table_full)
                                begin
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    scan_go_reg <= 1'b1;
                                    state_reg   <= S_KEY_SCAN;
                                end
                            end
                            CMD_FINISH:
                            begin
                                alpha_reg <= '0;
                                state_reg <= S_FIN_NEXT;
                            end
                            CMD_ENCRYPT, CMD_DECRYPT:
                            begin
                                if (!tbl_ready_reg)
                                begin
                                    res_status_reg <= ST_NOT_READY;
                                    state_reg      <= S_DONE;
                                end
                                else
                                begin
                                    key_reg     <= (req.cmd == CMD_ENCRYPT)
                                                   ? cap_char(req.in_char) : req.in_char;
                                    scan_go_reg <= 1'b1;
                                    state_reg   <= S_CIPH_SCAN;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end

                S_KEY_SCAN:
                begin
                    scan_go_reg <= 1'b0;
                    if (scan_res.done)
                    begin
                        if (!scan_res.hit)
                        begin
                            fill_reg <= fill_reg + CW'(1);
                        end
                        state_reg <= S_DONE;
                    end
                end

                S_FIN_NEXT:
                begin
                    if (table_full || alpha_reg == ALPHA_CNT_W'(ALPHA_LEN))
                    begin
                        tbl_ready_reg <= 1'b1;
                        state_reg     <= S_DONE;
                    end
                    else
                    begin
                        key_reg     <= ALPHABET[alpha_reg[ALPHA_IDX_W-1:0]];
                        scan_go_reg <= 1'b1;
                        state_reg   <= S_FIN_SCAN;
                    end
                end

                S_FIN_SCAN:
                begin
                    scan_go_reg <= 1'b0;
                    if (scan_res.done)
                    begin
                        if (!scan_res.hit)
                        begin
                            fill_reg <= fill_reg + CW'(1);
                        end
                        alpha_reg <= alpha_reg + ALPHA_CNT_W'(1);
                        state_reg <= S_FIN_NEXT;
                    end
                end

                S_CIPH_SCAN:
                begin
                    scan_go_reg <= 1'b0;
                    if (scan_res.done)
                    begin
                        if (scan_res.hit)
                        begin
                            lu_addr_reg <= lu_addr_next;
                            state_reg   <= S_LOOKUP;
                        end
                        else
                        begin
                            // Unknown symbol: pass the original character through.
                            res_char_reg   <= char_reg;
                            res_status_reg <= ST_MISS;
                            state_reg      <= S_DONE;
                        end
                    end
                end

                S_LOOKUP:
                begin
                    state_reg <= S_LOOKUP_DATA;
                end

                S_LOOKUP_DATA:
                begin
                    res_char_reg <= rd_data;
                    state_reg    <= S_DONE;
                end

                S_DONE:
                begin
                    // Hold the result until the output register is free.
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_char_reg   <= res_char_reg;
                        out_status_reg <= res_status_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_write_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !table_full)
        else $error("table write while table is full");

    a_ready_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_ready_reg |-> table_full)
        else $error("table marked ready but not full");

    a_scan_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        scan_res.done |-> (state_reg == S_KEY_SCAN || state_reg == S_FIN_SCAN
                           || state_reg == S_CIPH_SCAN))
        else $error("search result outside a search state");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted item did not start the sequencer");

endmodule

`default_nettype wire

// File: tb/keyword_table_substitution_cipher_unit_chk.sv
// Checker for the keyword table cipher: predicts each response from the request stream and compares.
`timescale 1ns / 1ps

module keyword_table_substitution_cipher_unit_chk
    import ktsc_pkg::*;
#(
    parameter int TABLE_ROWS = 8
) (
    input  logic  clk,
    input  logic  rst_n,
    ktsc_req_if   req,
    ktsc_rsp_if   rsp,
    output int    fail_count,
    output int    outstanding
);

    localparam int TABLE_SIZE = TABLE_ROWS * TABLE_COLS;

    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] st;
    } cipher_out_t;

    cipher_out_t expected_q [$];
    logic [7:0]  key_table [0:63];
    int          table_fill = 0;
    logic        table_done = 1'b0;

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    function automatic logic [7:0] upcase(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A)
        begin
            return c - 8'h20;
        end
        if (c >= 8'hE0)
        begin
            return c - 8'h20;
        end
        if (c == 8'hB8)
        begin
            return 8'hA8;
        end
        return c;
    endfunction

    // Position of c among the filled entries, -1 when absent.
    function automatic int table_index(input logic [7:0] c);
        for (int i = 0; i < table_fill; i++)
        begin
            if (key_table[i] == c)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic void add_symbol(input logic [7:0] c);
        if (table_fill >= TABLE_SIZE || table_fill >= 64)
        begin
            return;
        end
        if (table_index(c) >= 0)
        begin
            return;
        end
        key_table[table_fill] = c;
        table_fill++;
    endfunction

    function automatic cipher_out_t predict(input logic [2:0] op, input logic [7:0] ch);
        cipher_out_t r;
        int          pos;
        int          row;
        int          col;
        int          nrow;
        logic [7:0]  probe;
        r.ch = 8'h00;
        r.st = ST_OK;
        case (op)
            CMD_CLEAR:
            begin
                table_fill = 0;
                table_done = 1'b0;
            end
            CMD_KEY:
            begin
                add_symbol(upcase(ch));
            end
            CMD_FINISH:
            begin
                for (int k = 0; k < ALPHA_LEN; k++)
                begin
                    add_symbol(ALPHABET[k]);
                end
                table_done = 1'b1;
            end
            CMD_ENCRYPT, CMD_DECRYPT:
            begin
                if (!table_done)
                begin
                    r.st = ST_NOT_READY;
                end
                else
                begin
                    probe = (op == CMD_ENCRYPT) ? upcase(ch) : ch;
                    pos   = table_index(probe);
                    if (pos < 0)
                    begin
                        r.ch = ch;
                        r.st = ST_MISS;
                    end
                    else
                    begin
                        row  = pos / TABLE_COLS;
                        col  = pos % TABLE_COLS;
                        nrow = (op == CMD_ENCRYPT) ? (row + 1) % TABLE_ROWS
                                                   : (row + TABLE_ROWS - 1) % TABLE_ROWS;
                        r.ch = key_table[(nrow * TABLE_COLS + col) & 63];
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("%0t chk: %s", $time, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cipher_out_t want;
        if (!rst_n)
        begin
            table_fill = 0;
            table_done = 1'b0;
            expected_q.delete();
            outstanding = 0;
        end
        else
        begin
            // pop before push: a response always belongs to an earlier item
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch($sformatf("response with nothing pending: out_char %h status %0d",
                                              rsp.out_char, rsp.status));
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp.out_char !== want.ch)
                    begin
                        report_mismatch($sformatf("out_char %h, want %h", rsp.out_char, want.ch));
                    end
                    if (rsp.status !== want.st)
                    begin
                        report_mismatch($sformatf("status %0d, want %0d", rsp.status, want.st));
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                expected_q.insert(expected_q.size(), predict(req.cmd, req.in_char));
            end
            outstanding = expected_q.size();
        end
    end

endmodule

// File: tb/keyword_table_substitution_cipher_unit_tb.sv
// Testbench top for the keyword table cipher: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 1ps

module keyword_table_substitution_cipher_unit_tb;
    import ktsc_pkg::*;

    localparam int ROWS       = 8;
    localparam int ITEM_GOAL  = 1100;
    localparam int HOLD_CYCLES = 600;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ktsc_req_if req ();
    ktsc_rsp_if rsp ();

    int fail_count;
    int outstanding;
    int tx_idle_pct = 14;
    int rx_idle_pct = 74;
    int stall_ask   = 0;
    int stall_seen  = 0;
    int hold_left   = 0;
    int items_sent  = 0;
    logic [7:0] recent_keys [$];

    always #5 clk = ~clk;

    keyword_table_substitution_cipher_unit #(
        .TABLE_ROWS (ROWS)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    keyword_table_substitution_cipher_unit_chk #(
        .TABLE_ROWS (ROWS)
    ) u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Response side: random back-pressure, plus a long hold whenever one is asked for.
    initial
    begin
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_seen != stall_ask)
            begin
                stall_seen = stall_ask;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_cmd(input logic [2:0] op, input logic [7:0] ch);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid   <= 1'b1;
        req.cmd     <= op;
        req.in_char <= ch;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_key(input logic [7:0] ch);
        recent_keys.insert(recent_keys.size(), ch);
        if (recent_keys.size() > 16)
        begin
            void'(recent_keys.pop_front());
        end
        send_cmd(CMD_KEY, ch);
    endtask

    // Mostly alphabet symbols, some lowercase forms, some recent keys, some raw bytes.
    function automatic logic [7:0] pick_text_char();
        int         r;
        logic [7:0] c;
        r = $urandom_range(99);
        c = ALPHABET[$urandom_range(ALPHA_LEN - 1)];
        if (r < 50)
        begin
            return c;
        end
        if (r < 75)
        begin
            if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'hC0 && c <= 8'hDF))
            begin
                c = c + 8'h20;
            end
            else if (c == 8'hA8)
            begin
                c = 8'hB8;
            end
            return c;
        end
        if (r < 88 && recent_keys.size() > 0)
        begin
            return recent_keys[$urandom_range(recent_keys.size() - 1)];
        end
        return 8'($urandom_range(255));
    endfunction

    // Clear, key, finish, then a stretch of text; optionally fill the table from keys alone.
    task automatic run_table_session(input bit fill_by_keys);
        int nkeys;
        int ntext;
        send_cmd(CMD_CLEAR, 8'($urandom_range(255)));
        recent_keys.delete();
        if (fill_by_keys)
        begin
            // enough random bytes to overflow the table, then keys get dropped
            repeat (90) send_key(8'($urandom_range(255)));
            send_cmd(CMD_ENCRYPT, pick_text_char());
        end
        else
        begin
            nkeys = $urandom_range(12);
            repeat (nkeys) send_key(pick_text_char());
        end
        if ($urandom_range(9) == 0)
        begin
            send_cmd($urandom_range(1) ? CMD_ENCRYPT : CMD_DECRYPT, pick_text_char());
        end
        send_cmd(CMD_FINISH, 8'($urandom_range(255)));
        ntext = $urandom_range(8, 36);
        repeat (ntext)
        begin
            case ($urandom_range(19))
                0:       send_key(pick_text_char());
                1:       send_cmd(CMD_FINISH, 8'($urandom_range(255)));
                default: send_cmd($urandom_range(1) ? CMD_ENCRYPT : CMD_DECRYPT,
                                  pick_text_char());
            endcase
        end
    endtask

    initial
    begin
        req.valid   = 1'b0;
        req.cmd     = CMD_CLEAR;
        req.in_char = 8'h00;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // cipher before any table exists, unused codes
        send_cmd(CMD_ENCRYPT, 8'h61);
        send_cmd(CMD_DECRYPT, 8'hFF);
        send_cmd(3'd5, 8'h00);
        send_cmd(3'd6, 8'hFF);
        send_cmd(3'd7, 8'h55);
        // keys: lowercase, small yo, cyrillic lowercase, a non-alphabet byte, a duplicate
        send_cmd(CMD_CLEAR, 8'hAA);
        send_key(8'h6B);
        send_key(8'hB8);
        send_key(8'hFF);
        send_key(8'h00);
        send_key(8'h4B);
        send_key(8'hE0);
        send_cmd(CMD_ENCRYPT, 8'h41);
        send_cmd(CMD_FINISH, 8'h00);
        send_cmd(CMD_FINISH, 8'hFF);
        send_key(8'h7A);
        send_cmd(CMD_ENCRYPT, 8'h61);
        send_cmd(CMD_ENCRYPT, 8'hB8);
        send_cmd(CMD_ENCRYPT, 8'h80);
        send_cmd(CMD_ENCRYPT, 8'h00);
        send_cmd(CMD_DECRYPT, 8'h6B);
        send_cmd(CMD_DECRYPT, 8'hDF);
        send_cmd(CMD_DECRYPT, 8'h21);
        send_cmd(CMD_CLEAR, 8'h00);
        send_cmd(CMD_ENCRYPT, 8'h41);

        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    tx_idle_pct = 14;
                    rx_idle_pct = 74;
                end
                1:
                begin
                    tx_idle_pct = 74;
                    rx_idle_pct = 14;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    // hold the response side while requests keep coming
                    stall_ask++;
                end
            endcase
            run_table_session(1'b1);
            while (items_sent < (ph + 1) * ITEM_GOAL / 3)
            begin
                if ($urandom_range(99) < 80)
                begin
                    run_table_session(1'b0);
                end
                else
                begin
                    repeat ($urandom_range(1, 8))
                        send_cmd(3'($urandom_range(7)), 8'($urandom_range(255)));
                end
            end
        end
        req.valid <= 1'b0;

        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
